FILE: rtl/svm_pkg.sv
// ----------------------------------------------------------------------------
// svm_pkg
// Shared types and constants of the stack machine execute unit.
// ----------------------------------------------------------------------------
package svm_pkg;

	// Default sizes of the machine stores
	localparam int DATA_DEPTH_DEF = 64;
	localparam int CALL_DEPTH_DEF = 16;
	localparam int REG_COUNT_DEF  = 256;

	// Serial divider length, one quotient bit per cycle
	localparam int DIV_STEPS = 32;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// Configuration register byte addresses
	localparam int          CFG_ADDR_W     = 2;
	localparam logic [1:0]  CFG_ENTRY_ADDR = 2'd0;

	// Instruction codes
	typedef enum logic [3:0] {
		OP_PUSH_IMM    = 4'd0,
		OP_PUSH_REG    = 4'd1,
		OP_ADD         = 4'd2,
		OP_MUL         = 4'd3,
		OP_CALL        = 4'd4,
		OP_JMP         = 4'd5,
		OP_RET         = 4'd6,
		OP_DIV         = 4'd7,
		OP_SUB         = 4'd8,
		OP_SETREG_CONST = 4'd9,
		OP_SETREG_REG  = 4'd10,
		OP_HALT        = 4'd11,
		OP_NOP         = 4'd12,
		OP_START       = 4'd13
	} op_t;

	// Machine status codes
	localparam logic [2:0] STS_RUN   = 3'd0;
	localparam logic [2:0] STS_HALT  = 3'd1;
	localparam logic [2:0] STS_DIV0  = 3'd2;
	localparam logic [2:0] STS_UNDER = 3'd3;
	localparam logic [2:0] STS_OVER  = 3'd4;
	localparam logic [2:0] STS_IDLE  = 3'd5;

	localparam logic [8:0]  EXIT_ERR  = 9'h1FF;
	localparam logic [31:0] BYTE_MASK = 32'h0000_00FF;

	// Controller to datapath commands
	typedef struct packed {
		logic latch;
		logic exec;
		logic div_step;
		logic wb;
		logic cap;
	} svm_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic go_div;
		logic go_wb;
	} svm_sts_t;

endpackage

FILE: rtl/svm_if.sv
// ----------------------------------------------------------------------------
// svm_in_if / svm_out_if
// Valid/ready channels for instruction items and result items.
// ----------------------------------------------------------------------------
interface svm_in_if;
	logic        valid;
	logic        ready;
	logic [3:0]  op;
	logic [31:0] immediate;
	logic [7:0]  reg_dest;
	logic [7:0]  reg_src;

	modport source (output valid, op, immediate, reg_dest, reg_src, input ready);
	modport sink   (input valid, op, immediate, reg_dest, reg_src, output ready);
endinterface

interface svm_out_if;
	logic              valid;
	logic              ready;
	logic [31:0]       next_ip;
	logic              running;
	logic [2:0]        status;
	logic signed [8:0] exit_code;
	logic [31:0]       stack_top;
	logic [6:0]        stack_depth;

	modport source (output valid, next_ip, running, status, exit_code, stack_top,
		stack_depth, input ready);
	modport sink   (input valid, next_ip, running, status, exit_code, stack_top,
		stack_depth, output ready);
endinterface

FILE: rtl/svm_ctrl.sv
// ----------------------------------------------------------------------------
// svm_ctrl
// Sequencer: accept, operand read, execute, serial divide, push back, top-of-stack read, result capture.
// ----------------------------------------------------------------------------
module svm_ctrl import svm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  svm_sts_t sts,
	output svm_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE, S_READ, S_EXEC, S_DIV, S_WB, S_TOP, S_CAP
	} state_t;

	state_t               state_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic                 out_vld_q;
	logic                 cap_ok;

	assign cap_ok    = (state_q == S_CAP) && (!out_vld_q || out_ready);
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_vld_q;

	// Command decode
	always_comb begin
		cmd          = '0;
		cmd.latch    = (state_q == S_IDLE) && in_valid;
		cmd.exec     = (state_q == S_EXEC);
		cmd.div_step = (state_q == S_DIV);
		cmd.wb       = (state_q == S_WB);
		cmd.cap      = cap_ok;
	end

	// State and output slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			div_cnt_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cap_ok)
				out_vld_q <= 1'b1;
			else if (out_ready)
				out_vld_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_READ;
				end
				S_READ: state_q <= S_EXEC;
				S_EXEC: begin
					div_cnt_q <= '0;
					if (sts.go_div)
						state_q <= S_DIV;
					else if (sts.go_wb)
						state_q <= S_WB;
					else
						state_q <= S_TOP;
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1))
						state_q <= S_WB;
				end
				S_WB:  state_q <= S_TOP;
				S_TOP: state_q <= S_CAP;
				S_CAP: begin
					if (cap_ok)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/svm_dpath.sv
// ----------------------------------------------------------------------------
// svm_dpath
// Machine state, stack and register memories, ALU, serial divider, result
// register.
// ----------------------------------------------------------------------------
module svm_dpath import svm_pkg::*; #(
	parameter int DATA_DEPTH = DATA_DEPTH_DEF,
	parameter int CALL_DEPTH = CALL_DEPTH_DEF,
	parameter int REG_COUNT  = REG_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  svm_cmd_t          cmd,
	output svm_sts_t          sts,
	input  logic [31:0]       entry_addr,
	input  logic [3:0]        in_op,
	input  logic [31:0]       in_imm,
	input  logic [7:0]        in_rdst,
	input  logic [7:0]        in_rsrc,
	output logic [31:0]       o_next_ip,
	output logic              o_running,
	output logic [2:0]        o_status,
	output logic signed [8:0] o_exit_code,
	output logic [31:0]       o_stack_top,
	output logic [6:0]        o_stack_depth
);

	localparam int DAW = $clog2(DATA_DEPTH);
	localparam int DCW = $clog2(DATA_DEPTH + 1);
	localparam int CAW = $clog2(CALL_DEPTH);
	localparam int CCW = $clog2(CALL_DEPTH + 1);
	localparam int RAW = $clog2(REG_COUNT);

	// Latched instruction
	logic [3:0]  op_q;
	logic [31:0] imm_q;
	logic [7:0]  rdst_q, rsrc_q;

	// Architectural state
	logic [31:0]    ip_q;
	logic [DCW-1:0] dcnt_q;
	logic [CCW-1:0] rcnt_q;
	logic           run_q;
	logic [2:0]     sts_q;
	logic [8:0]     exit_q;

	// Memories and registered read data
	logic [31:0] dmem [DATA_DEPTH];
	logic [31:0] cmem [CALL_DEPTH];
	logic [31:0] rmem [REG_COUNT];
	logic [REG_COUNT-1:0] rvld_q;
	logic [31:0] da_q, db_q, ca_q, rf_q;
	logic        rf_ok_q;

	// ALU result and divider
	logic [31:0] res_q, dv_rem_q, dv_quo_q, dv_den_q;
	logic [32:0] dv_trial;

	// Execute decode
	logic [31:0]    x_ip;
	logic [DCW-1:0] x_dcnt;
	logic [CCW-1:0] x_rcnt;
	logic           x_run;
	logic [2:0]     x_sts;
	logic [8:0]     x_exit;
	logic           x_dwe, x_cwe, x_rwe, x_rclr, x_div, x_wb;
	logic [31:0]    x_push, x_res, x_regval;

	logic [DAW-1:0] d_top_idx, d_nxt_idx;
	logic [CAW-1:0] c_top_idx;
	logic [7:0]     rf_sel;
	logic [RAW-1:0] rf_idx;
	logic           rf_sel_ok, rd_ok, full, rfull, two;
	logic           d_we;
	logic [31:0]    d_wdata;

	assign d_top_idx = DAW'(dcnt_q - DCW'(1));
	assign d_nxt_idx = DAW'(dcnt_q - DCW'(2));
	assign c_top_idx = CAW'(rcnt_q - CCW'(1));
	assign rf_sel    = (op_q == OP_SETREG_REG) ? rsrc_q : rdst_q;
	assign rf_sel_ok = {1'b0, rf_sel} < 9'(REG_COUNT);
	assign rf_idx    = rf_sel[RAW-1:0];
	assign rd_ok     = {1'b0, rdst_q} < 9'(REG_COUNT);
	assign full      = dcnt_q >= DCW'(DATA_DEPTH);
	assign rfull     = rcnt_q >= CCW'(CALL_DEPTH);
	assign two       = dcnt_q >= DCW'(2);
	assign x_regval  = rf_ok_q ? rf_q : 32'd0;

	// Instruction latch
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q   <= in_op;
			imm_q  <= in_imm;
			rdst_q <= in_rdst;
			rsrc_q <= in_rsrc;
		end
	end

	// Execute: next machine state for the latched instruction
	always_comb begin
		x_ip   = ip_q;
		x_dcnt = dcnt_q;
		x_rcnt = rcnt_q;
		x_run  = run_q;
		x_sts  = sts_q;
		x_exit = exit_q;
		x_dwe  = 1'b0;
		x_cwe  = 1'b0;
		x_rwe  = 1'b0;
		x_rclr = 1'b0;
		x_div  = 1'b0;
		x_wb   = 1'b0;
		x_push = (op_q == OP_PUSH_REG) ? x_regval : imm_q;
		x_res  = da_q + db_q;
		if (op_q == OP_START) begin
			x_dcnt = '0;
			x_rcnt = '0;
			x_rclr = 1'b1;
			x_ip   = entry_addr;
			x_exit = '0;
			x_sts  = STS_RUN;
			x_run  = 1'b1;
		end else if (run_q) begin
			x_ip = ip_q + 32'd1;
			unique case (op_q)
				OP_PUSH_IMM, OP_PUSH_REG: begin
					x_ip = ip_q + ((op_q == OP_PUSH_IMM) ? 32'd5 : 32'd2);
					if (full) begin
						x_run = 1'b0; x_sts = STS_OVER; x_exit = EXIT_ERR;
					end else begin
						x_dwe  = 1'b1;
						x_dcnt = dcnt_q + 1'b1;
					end
				end
				OP_ADD, OP_MUL, OP_SUB, OP_DIV: begin
					if (!two) begin
						x_run = 1'b0; x_sts = STS_UNDER; x_exit = EXIT_ERR;
					end else begin
						x_dcnt = dcnt_q - DCW'(2);
						if (op_q == OP_DIV) begin
							if (db_q == 32'd0) begin
								x_run = 1'b0; x_sts = STS_DIV0; x_exit = EXIT_ERR;
							end else
								x_div = 1'b1;
						end else begin
							x_wb = 1'b1;
							if (op_q == OP_MUL)
								x_res = da_q * db_q;
							else if (op_q == OP_SUB)
								x_res = da_q - db_q;
						end
					end
				end
				OP_CALL: begin
					if (rfull) begin
						x_run = 1'b0; x_sts = STS_OVER; x_exit = EXIT_ERR;
					end else begin
						x_cwe  = 1'b1;
						x_rcnt = rcnt_q + 1'b1;
						x_ip   = imm_q;
					end
				end
				OP_JMP: x_ip = imm_q;
				OP_RET: begin
					if (rcnt_q == '0) begin
						x_run = 1'b0; x_sts = STS_UNDER; x_exit = EXIT_ERR;
					end else begin
						x_rcnt = rcnt_q - 1'b1;
						x_ip   = ca_q;
					end
				end
				OP_SETREG_CONST, OP_SETREG_REG: begin
					x_ip  = ip_q + ((op_q == OP_SETREG_CONST) ? 32'd6 : 32'd3);
					x_rwe = rd_ok;
				end
				OP_HALT: begin
					if (dcnt_q == '0) begin
						x_run = 1'b0; x_sts = STS_UNDER; x_exit = EXIT_ERR;
					end else begin
						x_dcnt = dcnt_q - 1'b1;
						x_exit = {1'b0, 8'(da_q & BYTE_MASK)};
						x_sts  = STS_HALT;
						x_run  = 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	assign sts.go_div = x_div;
	assign sts.go_wb  = x_wb;

	// Machine state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ip_q   <= '0;
			dcnt_q <= '0;
			rcnt_q <= '0;
			run_q  <= 1'b0;
			sts_q  <= STS_IDLE;
			exit_q <= '0;
			rvld_q <= '0;
		end else begin
			if (cmd.exec) begin
				ip_q   <= x_ip;
				dcnt_q <= x_dcnt;
				rcnt_q <= x_rcnt;
				run_q  <= x_run;
				sts_q  <= x_sts;
				exit_q <= x_exit;
				if (x_rclr)
					rvld_q <= '0;
				else if (x_rwe)
					rvld_q[rdst_q[RAW-1:0]] <= 1'b1;
			end else if (cmd.wb)
				dcnt_q <= dcnt_q + 1'b1;
		end
	end

	// Data stack: push write, top and next reads
	assign d_we    = (cmd.exec && x_dwe) || cmd.wb;
	assign d_wdata = cmd.wb ? ((op_q == OP_DIV) ? dv_quo_q : res_q) : x_push;

	always_ff @(posedge clk) begin
		if (d_we)
			dmem[dcnt_q[DAW-1:0]] <= d_wdata;
		da_q <= dmem[d_top_idx];
		db_q <= dmem[d_nxt_idx];
	end

	// Return stack
	always_ff @(posedge clk) begin
		if (cmd.exec && x_cwe)
			cmem[rcnt_q[CAW-1:0]] <= ip_q + 32'd5;
		ca_q <= cmem[c_top_idx];
	end

	// Register file; entries without a valid bit read as zero
	always_ff @(posedge clk) begin
		if (cmd.exec && x_rwe)
			rmem[rdst_q[RAW-1:0]] <= (op_q == OP_SETREG_CONST) ? imm_q : x_regval;
		rf_q    <= rmem[rf_idx];
		rf_ok_q <= rf_sel_ok && rvld_q[rf_idx];
	end

	// ALU result and restoring divider, one quotient bit per step
	assign dv_trial = {dv_rem_q, dv_quo_q[31]} - {1'b0, dv_den_q};

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_q    <= x_res;
			dv_quo_q <= da_q;
			dv_den_q <= db_q;
			dv_rem_q <= '0;
		end else if (cmd.div_step) begin
			if (!dv_trial[32]) begin
				dv_rem_q <= dv_trial[31:0];
				dv_quo_q <= {dv_quo_q[30:0], 1'b1};
			end else begin
				dv_rem_q <= {dv_rem_q[30:0], dv_quo_q[31]};
				dv_quo_q <= {dv_quo_q[30:0], 1'b0};
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			o_next_ip     <= ip_q;
			o_running     <= run_q;
			o_status      <= sts_q;
			o_exit_code   <= exit_q;
			o_stack_top   <= (dcnt_q != '0) ? da_q : 32'd0;
			o_stack_depth <= 7'(dcnt_q);
		end
	end

endmodule

FILE: rtl/stack_vm_execute_unit.sv
// ----------------------------------------------------------------------------
// stack_vm_execute_unit
// Executes one decoded stack machine instruction per input item.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries decoded instructions (op, immediate, reg_dest, reg_src);
//   out_ch returns one result item per instruction with the machine state
//   after it. Both are valid/ready; an item moves when both are high.
//   The APB port holds entry_address at byte address 0; write it while idle.
// Sequencing:
//   One instruction at a time: accept, operand read, execute, top-of-stack
//   read and capture; arithmetic ops that push add a write-back step.
//   Divide first runs a 32-step serial divider. The memory read registers
//   of the stacks and register file call for the operand and top reads.
// Reset:
//   Machine idle (status 5), pointer and counts zero, register file reads
//   as zero through per-entry valid bits; no clearing pass is needed.
// Stall:
//   A result waits in the output register; the next instruction is taken
//   meanwhile and its result holds in the capture step until the slot frees.
// ----------------------------------------------------------------------------
module stack_vm_execute_unit import svm_pkg::*; #(
	parameter int DATA_DEPTH = DATA_DEPTH_DEF,
	parameter int CALL_DEPTH = CALL_DEPTH_DEF,
	parameter int REG_COUNT  = REG_COUNT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	svm_in_if.sink                in_ch,
	svm_out_if.source             out_ch,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	svm_cmd_t    cmd;
	svm_sts_t    sts;
	logic [31:0] entry_q;

	// Configuration register
	assign pready = 1'b1;
	assign prdata = (paddr == CFG_ENTRY_ADDR) ? entry_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			entry_q <= '0;
		else if (psel && penable && pwrite && paddr == CFG_ENTRY_ADDR)
			entry_q <= pwdata;
	end

	svm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	svm_dpath #(
		.DATA_DEPTH (DATA_DEPTH),
		.CALL_DEPTH (CALL_DEPTH),
		.REG_COUNT  (REG_COUNT)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.entry_addr    (entry_q),
		.in_op         (in_ch.op),
		.in_imm        (in_ch.immediate),
		.in_rdst       (in_ch.reg_dest),
		.in_rsrc       (in_ch.reg_src),
		.o_next_ip     (out_ch.next_ip),
		.o_running     (out_ch.running),
		.o_status      (out_ch.status),
		.o_exit_code   (out_ch.exit_code),
		.o_stack_top   (out_ch.stack_top),
		.o_stack_depth (out_ch.stack_depth)
	);

`ifndef SYNTHESIS
	// One instruction in flight: no accept right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> !in_ch.ready)
		else $error("instruction accepted while one is in flight");

	// Running flag agrees with the status code
	a_run_sts: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.running == (out_ch.status == STS_RUN)))
		else $error("running flag disagrees with status");

	// Error stops report exit code -1
	a_err_exit: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && (out_ch.status == STS_DIV0 || out_ch.status == STS_UNDER ||
		out_ch.status == STS_OVER) |-> out_ch.exit_code == EXIT_ERR)
		else $error("error status without error exit code");
`endif

endmodule
